>>> rtl/fwrv_pkg.sv
// ============================================================================
// fwrv_pkg
// Shared types, codes and the field layout table of the record validator.
// ============================================================================
package fwrv_pkg;

    // Every record is this many bytes once CR and LF are removed.
    localparam int RECORD_WIDTH = 120;
    localparam int POS_BITS     = 7;
    localparam int LAYOUT_DEPTH = 35;
    localparam int IDX_BITS     = 6;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(LAYOUT_DEPTH - 1);
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(RECORD_WIDTH - 1);

    // Result record_number is shown saturated to this many bits.
    localparam int RECNUM_BITS = 20;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_TRAILER = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ORDER     = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_BAD_FIELD = 3'd3,
        ST_PARTIAL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_KANA  = 2'd1,
        CLS_SPACE = 2'd2
    } cls_t;

    // Byte classes and record type, worked out by the front part.
    typedef struct packed {
        logic       last;
        logic       crlf;
        logic       is_digit;
        logic       is_space;
        logic       is_kana;
        logic       below_zero;
        logic       type_ok;
        kind_t      kind;
        logic [3:0] digit;
    } byte_info_t;

    // One field of a layout: end position (start plus length), class and
    // whether an all-space field is accepted instead.
    typedef struct packed {
        logic [POS_BITS-1:0] field_end;
        cls_t                cls;
        logic                alt_spaces;
    } layout_t;

    function automatic logic [IDX_BITS-1:0] kind_base(input kind_t kind);
        logic [IDX_BITS-1:0] base;
        case (kind)
            KIND_HEADER:  base = IDX_BITS'(0);
            KIND_DATA:    base = IDX_BITS'(13);
            KIND_TRAILER: base = IDX_BITS'(29);
            KIND_END:     base = IDX_BITS'(33);
            default:      base = IDX_BITS'(0);
        endcase
        return base;
    endfunction

    function automatic layout_t mk(input int unsigned fend, input cls_t cls,
                                   input logic alt);
        layout_t entry;
        entry.field_end  = POS_BITS'(fend);
        entry.cls        = cls;
        entry.alt_spaces = alt;
        return entry;
    endfunction

    // Constant layout table; entries hold start plus length.
    function automatic layout_t layout_lookup(input logic [IDX_BITS-1:0] idx);
        layout_t entry;
        case (idx)
            // Header record.
            6'd0:    entry = mk(1,   CLS_DIGIT, 1'b0);
            6'd1:    entry = mk(3,   CLS_DIGIT, 1'b0);
            6'd2:    entry = mk(4,   CLS_DIGIT, 1'b0);
            6'd3:    entry = mk(14,  CLS_DIGIT, 1'b0);
            6'd4:    entry = mk(54,  CLS_KANA,  1'b0);
            6'd5:    entry = mk(58,  CLS_DIGIT, 1'b0);
            6'd6:    entry = mk(62,  CLS_DIGIT, 1'b0);
            6'd7:    entry = mk(77,  CLS_KANA,  1'b0);
            6'd8:    entry = mk(80,  CLS_DIGIT, 1'b0);
            6'd9:    entry = mk(95,  CLS_KANA,  1'b0);
            6'd10:   entry = mk(96,  CLS_DIGIT, 1'b1);
            6'd11:   entry = mk(103, CLS_DIGIT, 1'b1);
            6'd12:   entry = mk(120, CLS_SPACE, 1'b0);
            // Data record.
            6'd13:   entry = mk(1,   CLS_DIGIT, 1'b0);
            6'd14:   entry = mk(5,   CLS_DIGIT, 1'b0);
            6'd15:   entry = mk(20,  CLS_KANA,  1'b0);
            6'd16:   entry = mk(23,  CLS_DIGIT, 1'b0);
            6'd17:   entry = mk(38,  CLS_KANA,  1'b0);
            6'd18:   entry = mk(42,  CLS_DIGIT, 1'b1);
            6'd19:   entry = mk(43,  CLS_DIGIT, 1'b0);
            6'd20:   entry = mk(50,  CLS_DIGIT, 1'b0);
            6'd21:   entry = mk(80,  CLS_KANA,  1'b0);
            6'd22:   entry = mk(90,  CLS_DIGIT, 1'b0);
            6'd23:   entry = mk(91,  CLS_DIGIT, 1'b1);
            6'd24:   entry = mk(101, CLS_KANA,  1'b0);
            6'd25:   entry = mk(111, CLS_KANA,  1'b0);
            6'd26:   entry = mk(112, CLS_DIGIT, 1'b1);
            6'd27:   entry = mk(113, CLS_KANA,  1'b0);
            6'd28:   entry = mk(120, CLS_SPACE, 1'b0);
            // Trailer record.
            6'd29:   entry = mk(1,   CLS_DIGIT, 1'b0);
            6'd30:   entry = mk(7,   CLS_DIGIT, 1'b0);
            6'd31:   entry = mk(19,  CLS_DIGIT, 1'b0);
            6'd32:   entry = mk(120, CLS_SPACE, 1'b0);
            // End record.
            6'd33:   entry = mk(1,   CLS_DIGIT, 1'b0);
            6'd34:   entry = mk(120, CLS_SPACE, 1'b0);
            default: entry = mk(120, CLS_SPACE, 1'b0);
        endcase
        return entry;
    endfunction

endpackage

>>> rtl/fwrv_front.sv
// ============================================================================
// fwrv_front
// Classifies each incoming byte: line breaks, character classes, record type.
// ============================================================================
module fwrv_front (
    input  logic                 data_last,
    input  logic [7:0]           data_byte,
    output fwrv_pkg::byte_info_t info
);
    import fwrv_pkg::*;

    logic is_digit;
    logic is_upper;
    logic is_hw_kana;
    logic is_punct;

    // Character class flags.
    assign is_digit   = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign is_upper   = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
    assign is_hw_kana = (data_byte >= 8'hB1) && (data_byte <= 8'hDF);
    assign is_punct   = (data_byte == 8'h28) || (data_byte == 8'h29) ||
                        (data_byte == 8'h2D) || (data_byte == 8'h2E);

    // Record type decode; only digits 1, 2, 8 and 9 name a known type.
    always_comb begin
        info.last       = data_last;
        info.crlf       = (data_byte == 8'h0D) || (data_byte == 8'h0A);
        info.is_digit   = is_digit;
        info.is_space   = (data_byte == 8'h20);
        info.is_kana    = is_digit || is_upper || is_hw_kana || is_punct ||
                          (data_byte == 8'h20);
        info.below_zero = (data_byte < 8'h30);
        info.digit      = data_byte[3:0];
        info.type_ok    = 1'b0;
        info.kind       = KIND_HEADER;
        case (data_byte)
            8'h31: begin
                info.type_ok = 1'b1;
                info.kind    = KIND_HEADER;
            end
            8'h32: begin
                info.type_ok = 1'b1;
                info.kind    = KIND_DATA;
            end
            8'h38: begin
                info.type_ok = 1'b1;
                info.kind    = KIND_TRAILER;
            end
            8'h39: begin
                info.type_ok = 1'b1;
                info.kind    = KIND_END;
            end
            default: begin
                info.type_ok = 1'b0;
                info.kind    = KIND_HEADER;
            end
        endcase
    end

endmodule

>>> rtl/fwrv_queue.sv
// ============================================================================
// fwrv_queue
// Short first-in first-out queue of classified bytes between front and back.
// ============================================================================
module fwrv_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fwrv_pkg::byte_info_t push_info,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output fwrv_pkg::byte_info_t head_info
);
    import fwrv_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    byte_info_t          slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_info = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_info;
        end
    end

endmodule

>>> rtl/fwrv_back.sv
// ============================================================================
// fwrv_back
// Record and field checker: tracks position, layout and sticky error, and
// holds each result in an output register.
// ============================================================================
module fwrv_back #(
    parameter int COUNT_BITS = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  fwrv_pkg::byte_info_t in_info,
    output logic                 in_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_record_kind,
    output logic [2:0]           m_status,
    output logic [3:0]           m_field_number,
    output logic [19:0]          m_record_number,
    output logic                 m_file_done
);
    import fwrv_pkg::*;

    localparam int WIDE_BITS = (COUNT_BITS > RECNUM_BITS) ? COUNT_BITS : RECNUM_BITS;
    localparam logic [WIDE_BITS-1:0] RECNUM_MAX = WIDE_BITS'({RECNUM_BITS{1'b1}});

    logic                  take;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [3:0]            prev_reg, prev_next;
    kind_t                 kind_reg, kind_next;
    logic [3:0]            cursor_reg, cursor_next;
    logic                  bad_reg, bad_next;
    logic                  spaces_reg, spaces_next;
    status_t               err_reg, err_next;
    logic [3:0]            efield_reg, efield_next;
    logic [COUNT_BITS-1:0] rec_reg, rec_next;

    logic                  emit;
    kind_t                 res_kind;
    status_t               res_status;
    logic [3:0]            res_field;
    logic                  res_done;
    logic [COUNT_BITS-1:0] res_count;

    logic                  type_start;
    kind_t                 kind_cur;
    logic [3:0]            cursor_cur;
    logic [IDX_BITS-1:0]   idx_sum;
    logic [IDX_BITS-1:0]   idx;
    layout_t               entry;
    logic                  class_ok;
    logic                  bad_now;
    logic                  spaces_now;
    logic [POS_BITS:0]     pos_plus;
    logic [WIDE_BITS-1:0]  count_wide;

    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    status_t               out_status_reg;
    logic [3:0]            out_field_reg;
    logic [19:0]           out_number_reg;
    logic                  out_done_reg;

    // A byte is taken whenever the output register is free or being drained.
    assign in_ready = !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // Kind and field cursor that the byte is checked against. A good type
    // byte opens a new record at its first field.
    assign type_start = !in_info.crlf && (err_reg == ST_OK) && (pos_reg == '0) &&
                        in_info.type_ok;
    assign kind_cur   = type_start ? in_info.kind : kind_reg;
    assign cursor_cur = type_start ? 4'd0 : cursor_reg;

    // Layout lookup for the current field.
    assign idx_sum = kind_base(kind_cur) + IDX_BITS'(cursor_cur);
    assign idx     = (idx_sum > IDX_LAST) ? IDX_LAST : idx_sum;
    assign entry   = layout_lookup(idx);
    assign pos_plus = {1'b0, pos_reg} + 1'b1;

    always_comb begin
        case (entry.cls)
            CLS_DIGIT: class_ok = in_info.is_digit;
            CLS_KANA:  class_ok = in_info.is_kana;
            CLS_SPACE: class_ok = in_info.is_space;
            default:   class_ok = in_info.is_space;
        endcase
    end

    // Per-byte record checking.
    always_comb begin
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        kind_next   = kind_reg;
        cursor_next = cursor_reg;
        bad_next    = bad_reg;
        spaces_next = spaces_reg;
        err_next    = err_reg;
        efield_next = efield_reg;
        rec_next    = rec_reg;
        emit        = 1'b0;
        res_kind    = kind_reg;
        res_status  = ST_OK;
        res_field   = 4'd0;
        res_count   = rec_reg;
        res_done    = 1'b0;
        bad_now     = 1'b0;
        spaces_now  = 1'b0;

        if (take) begin
            if (!in_info.crlf) begin
                // Record type at the first byte of a record.
                if (err_reg == ST_OK && pos_reg == '0) begin
                    if (in_info.below_zero || (in_info.is_digit && prev_reg > in_info.digit)) begin
                        err_next = ST_ORDER;
                    end else if (in_info.type_ok) begin
                        prev_next   = in_info.digit;
                        kind_next   = in_info.kind;
                        cursor_next = 4'd0;
                        bad_next    = 1'b0;
                        spaces_next = 1'b1;
                    end else begin
                        err_next = ST_UNKNOWN;
                    end
                    if (err_next != ST_OK) begin
                        kind_next   = KIND_HEADER;
                        efield_next = 4'd0;
                        emit        = 1'b1;
                        res_kind    = KIND_HEADER;
                        res_status  = err_next;
                        res_field   = 4'd0;
                        res_count   = rec_reg;
                    end
                end

                // Field class check and field close.
                if (err_next == ST_OK) begin
                    bad_now    = bad_next || !class_ok;
                    spaces_now = spaces_next && in_info.is_space;
                    if (pos_plus >= {1'b0, entry.field_end}) begin
                        if (bad_now && !(entry.alt_spaces && spaces_now)) begin
                            err_next    = ST_BAD_FIELD;
                            efield_next = cursor_next;
                            emit        = 1'b1;
                            res_kind    = kind_next;
                            res_status  = ST_BAD_FIELD;
                            res_field   = cursor_next;
                            res_count   = rec_reg;
                        end else begin
                            cursor_next = cursor_next + 1'b1;
                            bad_next    = 1'b0;
                            spaces_next = 1'b1;
                            if (pos_reg == POS_LAST) begin
                                emit       = 1'b1;
                                res_kind   = kind_next;
                                res_status = ST_OK;
                                res_field  = 4'd0;
                                res_count  = rec_reg;
                            end
                        end
                    end else begin
                        bad_next    = bad_now;
                        spaces_next = spaces_now;
                    end
                end

                // Byte position and saturating record count.
                if (pos_reg >= POS_LAST) begin
                    pos_next = '0;
                    if (rec_reg != {COUNT_BITS{1'b1}}) begin
                        rec_next = rec_reg + 1'b1;
                    end
                end else begin
                    pos_next = pos_plus[POS_BITS-1:0];
                end
            end

            // Closing result on the last byte of the file.
            if (in_info.last) begin
                if (pos_next != '0) begin
                    res_kind   = kind_next;
                    res_status = ST_PARTIAL;
                    res_field  = 4'd0;
                    res_count  = rec_next;
                end else if (!emit) begin
                    res_kind   = kind_next;
                    res_status = err_next;
                    res_field  = efield_next;
                    res_count  = rec_next;
                end
                emit        = 1'b1;
                res_done    = 1'b1;
                pos_next    = '0;
                prev_next   = 4'd0;
                kind_next   = KIND_HEADER;
                cursor_next = 4'd0;
                bad_next    = 1'b0;
                spaces_next = 1'b1;
                err_next    = ST_OK;
                efield_next = 4'd0;
                rec_next    = '0;
            end
        end
    end

    assign count_wide = WIDE_BITS'(res_count);

    // Checker state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            prev_reg   <= 4'd0;
            kind_reg   <= KIND_HEADER;
            cursor_reg <= 4'd0;
            bad_reg    <= 1'b0;
            spaces_reg <= 1'b1;
            err_reg    <= ST_OK;
            efield_reg <= 4'd0;
            rec_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            kind_reg   <= kind_next;
            cursor_reg <= cursor_next;
            bad_reg    <= bad_next;
            spaces_reg <= spaces_next;
            err_reg    <= err_next;
            efield_reg <= efield_next;
            rec_reg    <= rec_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with each new result.
    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_kind_reg   <= res_kind;
            out_status_reg <= res_status;
            out_field_reg  <= res_field;
            out_number_reg <= (count_wide > RECNUM_MAX) ? RECNUM_MAX[RECNUM_BITS-1:0]
                                                        : count_wide[RECNUM_BITS-1:0];
            out_done_reg   <= res_done;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_record_kind   = out_kind_reg;
    assign m_status        = out_status_reg;
    assign m_field_number  = out_field_reg;
    assign m_record_number = out_number_reg;
    assign m_file_done     = out_done_reg;

endmodule

>>> rtl/fixed_width_record_validator.sv
// ============================================================================
// fixed_width_record_validator
// Checks a byte stream of fixed-width records against per-type field layouts.
// ============================================================================
// Input channel (s_): one file byte per transfer, s_last_byte marks the end of
// the file. CR and LF bytes are dropped; the rest form 120-byte records.
// Result channel (m_): at most one result per input byte: one at the end of
// each good record, one at the first error, and exactly one with
// m_file_done set at the last byte of the file.
// Throughput is one byte per clock while the receiver does not stall. An
// accepted byte takes this path: the classified byte passes through
// a four-entry queue, and the checker writes its result into the output
// register. The layout lookup and field compare in the back part are
// combinational, which sets the one-byte-per-clock rate.
// When the receiver stalls, the result waits in the output register, the
// checker stops, and the queue absorbs up to four more bytes before
// s_ready falls. After reset, and after every last byte, all record state is
// clear and the next byte starts a new file.
// ============================================================================
module fixed_width_record_validator #(
    parameter int COUNT_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [2:0]  m_status,
    output logic [3:0]  m_field_number,
    output logic [19:0] m_record_number,
    output logic        m_file_done
);
    import fwrv_pkg::*;

    byte_info_t front_info;
    byte_info_t head_info;
    logic       queue_full;
    logic       queue_not_empty;
    logic       back_ready;
    logic       push;
    logic       pop;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;
    assign pop     = queue_not_empty && back_ready;

    // Front part: byte classification.
    fwrv_front u_front (
        .data_last (s_last_byte),
        .data_byte (s_data_byte),
        .info      (front_info)
    );

    // Decoupling queue.
    fwrv_queue #(
        .DEPTH (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_info (front_info),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_info (head_info)
    );

    // Back part: record checking and result register.
    fwrv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (queue_not_empty),
        .in_info         (head_info),
        .in_ready        (back_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_status        (m_status),
        .m_field_number  (m_field_number),
        .m_record_number (m_record_number),
        .m_file_done     (m_file_done)
    );

endmodule

>>> rtl/fwrv_checker.sv
// ============================================================================
// fwrv_checker
// Port-level checks on the result channel of the record validator.
// ============================================================================
module fwrv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_record_kind,
    input logic [2:0]  m_status,
    input logic [3:0]  m_field_number,
    input logic [19:0] m_record_number,
    input logic        m_file_done
);
    import fwrv_pkg::*;

    // A stalled result holds until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_record_kind) &&
        $stable(m_status) && $stable(m_field_number) &&
        $stable(m_record_number) && $stable(m_file_done))
        else $error("result changed while stalled");

    // Status codes stay within the defined set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_PARTIAL)
        else $error("undefined status code");

    // Only a bad field names a field number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_BAD_FIELD |-> m_field_number == 4'd0)
        else $error("field number without bad field");

    // A partial record is only reported when the file closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PARTIAL |-> m_file_done)
        else $error("partial record outside file close");

endmodule

bind fixed_width_record_validator fwrv_checker u_fwrv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_record_kind   (m_record_kind),
    .m_status        (m_status),
    .m_field_number  (m_field_number),
    .m_record_number (m_record_number),
    .m_file_done     (m_file_done)
);
